// ----- src/hrlh_pkg.sv -----
// Package for the heater radio link handler: request and result types,
// codes and frame constants, and the control frame byte table.
// No dependencies.
package hrlh_pkg;

	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_POLL   = 2'd1;
	localparam logic [1:0] REQ_BOOST  = 2'd2;
	localparam logic [1:0] REQ_CANCEL = 2'd3;

	localparam logic [2:0] KIND_TX     = 3'd0;
	localparam logic [2:0] KIND_HEATER = 3'd1;
	localparam logic [2:0] KIND_BUDDY  = 3'd2;
	localparam logic [2:0] KIND_SENDER = 3'd3;
	localparam logic [2:0] KIND_DROP   = 3'd4;

	localparam logic [2:0] STATE_HOT   = 3'd0;
	localparam logic [2:0] STATE_OVER  = 3'd1;
	localparam logic [2:0] STATE_BOOST = 3'd2;
	localparam logic [2:0] STATE_SOLAR = 3'd3;
	localparam logic [2:0] STATE_OFF   = 3'd4;

	localparam logic [2:0] ENERGY_NONE = 3'd5;

	localparam logic [7:0] TYPE_HEATER = 8'h22;
	localparam logic [7:0] TYPE_BUDDY  = 8'h21;
	localparam logic [7:0] TYPE_SENDER = 8'h01;

	localparam logic [7:0] MODE_FIRST = 8'hCA;
	localparam logic [7:0] MODE_CUMUL = 8'hCB;
	localparam logic [7:0] MODE_LAST  = 8'hCE;

	localparam logic [5:0] LEN_MIN    = 6'd10;
	localparam logic [5:0] LEN_MAX    = 6'd62;
	localparam logic [5:0] LEN_CAP    = 6'd63;
	localparam logic [5:0] LEN_TYPED  = 6'd28;
	localparam logic [5:0] LEN_SENDER = 6'd44;

	localparam int CAP_BYTES = 29;
	localparam logic [4:0] FRAME_LAST = 5'd28;
	localparam logic [2:0] SLOT_LAST  = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         rx_byte;
		logic               rx_last;
		logic signed [11:0] rssi_tenths;
		logic [7:0]         boost_dur;
	} req_item_t;

	typedef struct packed {
		logic [2:0]         out_kind;
		logic [7:0]         tx_byte;
		logic               tx_last;
		logic signed [15:0] heat_power;
		logic signed [31:0] import_raw;
		logic signed [31:0] energy_value;
		logic [2:0]         energy_kind;
		logic [7:0]         boost_left;
		logic [2:0]         heat_state;
		logic [1:0]         warnings;
		logic [31:0]        packet_count;
	} res_item_t;

	typedef struct packed {
		logic               known;
		logic [15:0]        addr;
		logic signed [11:0] best_rssi;
		logic               batt_low;
		logic [31:0]        count;
	} link_state_t;

	typedef struct packed {
		logic               learn;
		logic [15:0]        new_addr;
		logic signed [11:0] new_best;
		logic               set_batt;
		logic               batt_val;
		logic               count_inc;
	} link_update_t;

	function automatic res_item_t clear_result();
		res_item_t r;
		r = '0;
		r.energy_kind = ENERGY_NONE;
		return r;
	endfunction

	function automatic logic [7:0] frame_byte(input logic [4:0] idx, input logic [15:0] addr,
			input logic [1:0] req, input logic [7:0] boost, input logic [7:0] code);
		logic [7:0] b;
		case (idx)
			5'd0: b = addr[15:8];
			5'd1: b = addr[7:0];
			5'd2: b = TYPE_BUDDY;
			5'd3: b = (req == REQ_POLL) ? 8'h08 : 8'h18;
			5'd4: b = 8'h92;
			5'd5: b = 8'h07;
			5'd8: b = 8'h24;
			5'd10: b = 8'hA0;
			5'd11: b = 8'hA0;
			5'd12: b = code;
			5'd14: b = 8'hA0;
			5'd15: b = 8'hA0;
			5'd16: b = 8'hC8;
			5'd17: b = (req == REQ_BOOST) ? boost : 8'h00;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- src/heater_radio_link_handler_top.sv -----
// Top level of the heater radio link handler: input register, packet byte
// capture, link state, control frame sequencer and result register.
// Depends on hrlh_pkg and hrlh_pkt_decode.
//
// Usage: requests enter on req_valid/req_ready/req_data and results leave on
// res_valid/res_ready/res_data. A received byte request with rx_last low
// gives no result; the last byte of a packet gives one result (report,
// buddy or sender accepted, or drop), registered through the input register
// and the result register. A poll, boost or cancel request, once an address
// is known, gives 29 frame byte results, the first after the frame start,
// then one per cycle while the receiver takes them. Without a known address
// it gives nothing. One request is taken per cycle while no frame is being
// sent and the receiver takes results; a frame holds the request path from
// its start cycle to its last byte, set by the frame byte sequencer, and one
// further request waits in the input register meanwhile.
// Reset clears the link state, the packet length and all valid flags.
// When the receiver stalls, the result register holds its result and the
// input side stops once the input register is full.
module heater_radio_link_handler_top
	import hrlh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req_data,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_data
);

	req_item_t                 in_s1;
	logic                      in_v_s1;
	logic [7:0]                cap_q [0:CAP_BYTES-1];
	logic [5:0]                rx_len_q;
	logic                      known_q;
	logic [15:0]               addr_q;
	logic signed [11:0]        best_q;
	logic                      batt_q;
	logic [2:0]                slot_q;
	logic [31:0]               count_q;
	logic                      busy_q;
	logic [4:0]                frm_idx_q;
	logic [1:0]                frm_req_q;
	logic [7:0]                frm_boost_q;
	logic [7:0]                frm_code_q;
	logic                      res_valid_q;
	res_item_t                 res_q;

	logic                      is_byte;
	logic                      need_out;
	logic                      out_free;
	logic                      fire;
	logic                      emit;
	logic                      pkt_end;
	logic                      frm_start;
	logic [5:0]                len_next;
	logic [2:0]                slot_cur;
	logic [CAP_BYTES-1:0][7:0] pkt;
	link_state_t               st;
	res_item_t                 dec_res;
	link_update_t              upd;
	res_item_t                 frm_res;

	assign is_byte   = (in_s1.req_type == REQ_BYTE);
	assign need_out  = is_byte ? in_s1.rx_last : known_q;
	assign out_free  = !res_valid_q || res_ready;
	assign fire      = in_v_s1 && !busy_q && (!need_out || out_free);
	assign emit      = busy_q && out_free;
	assign pkt_end   = fire && is_byte && in_s1.rx_last;
	assign frm_start = fire && !is_byte && known_q;
	assign req_ready = !in_v_s1 || fire;
	assign len_next  = (rx_len_q == LEN_CAP) ? LEN_CAP : rx_len_q + 6'd1;
	assign slot_cur  = (slot_q > SLOT_LAST) ? 3'd0 : slot_q;

	always_comb begin
		for (int k = 0; k < CAP_BYTES; k++) begin
			pkt[k] = (rx_len_q == 6'(k)) ? in_s1.rx_byte : cap_q[k];
		end
	end

	assign st.known     = known_q;
	assign st.addr      = addr_q;
	assign st.best_rssi = best_q;
	assign st.batt_low  = batt_q;
	assign st.count     = count_q;

	hrlh_pkt_decode u_decode (
		.pkt  (pkt),
		.len  (len_next),
		.rssi (in_s1.rssi_tenths),
		.st   (st),
		.res  (dec_res),
		.upd  (upd)
	);

	always_comb begin
		frm_res = clear_result();
		frm_res.out_kind = KIND_TX;
		frm_res.tx_byte = frame_byte(frm_idx_q, addr_q, frm_req_q, frm_boost_q, frm_code_q);
		frm_res.tx_last = (frm_idx_q == FRAME_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (req_ready) begin
			in_v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			in_s1 <= req_data;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CAP_BYTES; k++) begin
			if (fire && is_byte && rx_len_q == 6'(k)) begin
				cap_q[k] <= in_s1.rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_len_q <= '0;
			known_q <= 1'b0;
			addr_q <= '0;
			best_q <= '0;
			batt_q <= 1'b0;
			count_q <= '0;
		end else if (fire && is_byte) begin
			rx_len_q <= in_s1.rx_last ? 6'd0 : len_next;
			if (in_s1.rx_last) begin
				if (upd.learn) begin
					known_q <= 1'b1;
					addr_q <= upd.new_addr;
					best_q <= upd.new_best;
				end
				if (upd.set_batt) begin
					batt_q <= upd.batt_val;
				end
				if (upd.count_inc) begin
					count_q <= count_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			frm_idx_q <= '0;
			slot_q <= '0;
		end else if (frm_start) begin
			busy_q <= 1'b1;
			frm_idx_q <= '0;
			slot_q <= (slot_cur == SLOT_LAST) ? 3'd0 : slot_cur + 3'd1;
		end else if (emit) begin
			busy_q <= (frm_idx_q != FRAME_LAST);
			frm_idx_q <= frm_idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (frm_start) begin
			frm_req_q <= in_s1.req_type;
			frm_boost_q <= in_s1.boost_dur;
			frm_code_q <= MODE_FIRST + 8'(slot_cur);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= emit || pkt_end;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= emit ? frm_res : dec_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !fire)
		else $error("request processed while a control frame is being sent");

	a_frame_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> frm_idx_q <= FRAME_LAST)
		else $error("control frame index out of range");

	a_frame_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && frm_idx_q == FRAME_LAST) |=> !busy_q)
		else $error("control frame did not end after its last byte");

	a_tx_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.tx_last) |-> res_q.out_kind == KIND_TX)
		else $error("tx_last set on a result that is not a frame byte");

	a_address_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		known_q |=> known_q)
		else $error("known address was lost");

endmodule

// ----- src/hrlh_pkt_decode.sv -----
// Packet decoder: checks a finished received packet and builds its result
// and the link state update. Depends on hrlh_pkg.
module hrlh_pkt_decode
	import hrlh_pkg::*;
(
	input  logic [CAP_BYTES-1:0][7:0] pkt,
	input  logic [5:0]                len,
	input  logic signed [11:0]        rssi,
	input  link_state_t               st,
	output res_item_t                 res,
	output link_update_t              upd
);

	logic [7:0]  ptype;
	logic [7:0]  b28;
	logic [7:0]  mode;
	logic [15:0] pkt_addr;
	logic [31:0] energy;
	logic        len_ok;
	logic        positive;
	logic [31:0] count_next;

	assign ptype      = pkt[2];
	assign b28        = (len > 6'd28) ? pkt[28] : 8'h00;
	assign mode       = pkt[24];
	assign pkt_addr   = {pkt[0], pkt[1]};
	assign energy     = {b28, pkt[27], pkt[26], pkt[25]};
	assign len_ok     = (len >= LEN_MIN) && (len <= LEN_MAX);
	assign positive   = (energy != 32'd0) && !energy[31];
	assign count_next = st.count + 32'd1;

	always_comb begin
		res = clear_result();
		res.out_kind = KIND_DROP;
		upd = '0;
		upd.new_addr = pkt_addr;
		upd.new_best = rssi;
		upd.batt_val = (pkt[12] == 8'h01);
		if (len_ok && ptype == TYPE_HEATER && len >= LEN_TYPED) begin
			upd.learn = !st.known;
			if (!st.known || pkt_addr == st.addr) begin
				upd.count_inc = 1'b1;
				res.out_kind = KIND_HEATER;
				res.heat_power = {pkt[17], pkt[16]};
				res.import_raw = {pkt[21], pkt[20], pkt[19], pkt[18]};
				if (mode >= MODE_FIRST && mode <= MODE_LAST &&
						(mode <= MODE_CUMUL || positive)) begin
					res.energy_value = energy;
					res.energy_kind = 3'(mode - MODE_FIRST);
				end
				res.boost_left = pkt[5];
				if (pkt[7] != 8'h00) begin
					res.heat_state = STATE_HOT;
				end else if (pkt[13] != 8'h00) begin
					res.heat_state = STATE_OVER;
				end else if (pkt[5] != 8'h00) begin
					res.heat_state = STATE_BOOST;
				end else if (pkt[6] == 8'h00) begin
					res.heat_state = STATE_SOLAR;
				end else begin
					res.heat_state = STATE_OFF;
				end
				res.warnings = {st.batt_low, pkt[13] != 8'h00};
				res.packet_count = count_next;
			end
		end else if (len_ok && ((ptype == TYPE_BUDDY && len >= LEN_TYPED) ||
				(ptype == TYPE_SENDER && len >= LEN_SENDER))) begin
			upd.learn = !st.known || (rssi > st.best_rssi);
			upd.set_batt = (ptype == TYPE_SENDER);
			upd.count_inc = 1'b1;
			res.out_kind = (ptype == TYPE_BUDDY) ? KIND_BUDDY : KIND_SENDER;
			res.packet_count = count_next;
		end
	end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for heater_radio_link_handler_top: directed and random packets and
// control requests, with expected results predicted per accepted request and compared in order.
// Depends on hrlh_pkg and the RTL under src.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hrlh_pkg::*;

	localparam logic [15:0] ADDR_A = 16'h5A3C;
	localparam logic [15:0] ADDR_B = 16'hC3A5;
	localparam logic [7:0] BATT_LOW_MARK = 8'h01;
	localparam int STORE_DEPTH = 64;
	localparam int TOTAL_ITEMS = 370;
	localparam int TAIL_ITEMS = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_item_t req_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_item_t res_data;

	req_item_t pending_reqs [$];
	res_item_t expected_results [$];
	logic [7:0] pkt [$];

	logic [7:0] rx_buf [STORE_DEPTH];
	logic [6:0] rx_len = '0;
	logic addr_known = 1'b0;
	logic [15:0] sys_addr = '0;
	logic signed [11:0] best_rssi = '0;
	logic batt_low = 1'b0;
	logic [2:0] req_slot = '0;
	logic [31:0] pkt_count = '0;

	int queued_total = 0;
	int accepted_total = 0;
	int results_seen = 0;
	int errors = 0;
	int n_frames = 0;
	int n_reports = 0;
	int n_accepts = 0;
	int n_drops = 0;
	int send_gap = 0;
	int send_pct = 0;
	int send_cycles = 0;
	int stall_left = 0;
	int take_pct = 0;
	int take_cycles = 0;

	heater_radio_link_handler_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] stored_byte(input int idx, input int len);
		if (idx >= len || idx >= STORE_DEPTH)
			return 8'h00;
		return rx_buf[idx];
	endfunction

	function automatic logic [31:0] stored_word(input int idx, input int len);
		return {stored_byte(idx + 3, len), stored_byte(idx + 2, len),
			stored_byte(idx + 1, len), stored_byte(idx, len)};
	endfunction

	task automatic take_address(input int len, input logic signed [11:0] rssi);
		sys_addr = {stored_byte(0, len), stored_byte(1, len)};
		addr_known = 1'b1;
		best_rssi = rssi;
	endtask

	task automatic decode_packet(input int len, input logic signed [11:0] rssi);
		res_item_t e;
		logic [7:0] ptype;
		logic [7:0] mode;
		logic [7:0] b5;
		logic [7:0] b13;
		logic [31:0] energy;
		ptype = stored_byte(2, len);
		e = '0;
		e.energy_kind = ENERGY_NONE;
		e.out_kind = KIND_DROP;
		if (len >= LEN_MIN && len <= LEN_MAX) begin
			if (ptype == TYPE_HEATER && len >= LEN_TYPED) begin
				if (!addr_known)
					take_address(len, rssi);
				if ({stored_byte(0, len), stored_byte(1, len)} == sys_addr) begin
					pkt_count++;
					b5 = stored_byte(5, len);
					b13 = stored_byte(13, len);
					mode = stored_byte(24, len);
					energy = stored_word(25, len);
					e.out_kind = KIND_HEATER;
					e.heat_power = {stored_byte(17, len), stored_byte(16, len)};
					e.import_raw = stored_word(18, len);
					if (mode >= MODE_FIRST && mode <= MODE_LAST
							&& (mode <= MODE_CUMUL || (energy != 0 && !energy[31]))) begin
						e.energy_value = energy;
						e.energy_kind = 3'(mode - MODE_FIRST);
					end
					e.boost_left = b5;
					if (stored_byte(7, len) != 0)
						e.heat_state = STATE_HOT;
					else if (b13 != 0)
						e.heat_state = STATE_OVER;
					else if (b5 != 0)
						e.heat_state = STATE_BOOST;
					else if (stored_byte(6, len) == 0)
						e.heat_state = STATE_SOLAR;
					else
						e.heat_state = STATE_OFF;
					e.warnings = {batt_low, b13 != 0};
					e.packet_count = pkt_count;
					n_reports++;
				end
			end else if ((ptype == TYPE_BUDDY && len >= LEN_TYPED)
					|| (ptype == TYPE_SENDER && len >= LEN_SENDER)) begin
				if (!addr_known || rssi > best_rssi)
					take_address(len, rssi);
				if (ptype == TYPE_SENDER)
					batt_low = (stored_byte(12, len) == BATT_LOW_MARK);
				pkt_count++;
				e.out_kind = (ptype == TYPE_BUDDY) ? KIND_BUDDY : KIND_SENDER;
				e.packet_count = pkt_count;
				n_accepts++;
			end
		end
		if (e.out_kind == KIND_DROP)
			n_drops++;
		expected_results.push_back(e);
	endtask

	task automatic predict_request(input req_item_t r);
		res_item_t e;
		logic [7:0] frame [0:FRAME_LAST];
		logic [2:0] slot;
		int len;
		if (r.req_type == REQ_BYTE) begin
			if (rx_len < STORE_DEPTH)
				rx_buf[rx_len] = r.rx_byte;
			if (rx_len < LEN_CAP)
				rx_len++;
			if (r.rx_last) begin
				len = rx_len;
				rx_len = '0;
				decode_packet(len, r.rssi_tenths);
			end
		end else if (addr_known) begin
			slot = (req_slot > SLOT_LAST) ? 3'd0 : req_slot;
			req_slot = (slot == SLOT_LAST) ? 3'd0 : slot + 3'd1;
			frame = '{default: 8'h00};
			frame[0] = sys_addr[15:8];
			frame[1] = sys_addr[7:0];
			frame[2] = TYPE_BUDDY;
			frame[3] = (r.req_type == REQ_POLL) ? 8'h08 : 8'h18;
			frame[4] = 8'h92;
			frame[5] = 8'h07;
			frame[8] = 8'h24;
			frame[10] = 8'hA0;
			frame[11] = 8'hA0;
			frame[12] = MODE_FIRST + 8'(slot);
			frame[14] = 8'hA0;
			frame[15] = 8'hA0;
			frame[16] = 8'hC8;
			if (r.req_type == REQ_BOOST)
				frame[17] = r.boost_dur;
			for (int k = 0; k <= FRAME_LAST; k++) begin
				e = '0;
				e.energy_kind = ENERGY_NONE;
				e.out_kind = KIND_TX;
				e.tx_byte = frame[k];
				e.tx_last = (k == FRAME_LAST);
				expected_results.push_back(e);
			end
			n_frames++;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: result %0d %s expected %0h, got %0h", $time, results_seen, name,
				want, got);
			errors++;
		end
	endtask

	task automatic check_result(input res_item_t got);
		res_item_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result %h, expected none", $time, got);
			errors++;
		end else begin
			want = expected_results.pop_front();
			check_field("out_kind", want.out_kind, got.out_kind);
			check_field("tx_byte", want.tx_byte, got.tx_byte);
			check_field("tx_last", want.tx_last, got.tx_last);
			check_field("heat_power", want.heat_power, got.heat_power);
			check_field("import_raw", want.import_raw, got.import_raw);
			check_field("energy_value", want.energy_value, got.energy_value);
			check_field("energy_kind", want.energy_kind, got.energy_kind);
			check_field("boost_left", want.boost_left, got.boost_left);
			check_field("heat_state", want.heat_state, got.heat_state);
			check_field("warnings", want.warnings, got.warnings);
			check_field("packet_count", want.packet_count, got.packet_count);
		end
		results_seen++;
	endtask

	function automatic logic signed [11:0] any_rssi();
		return 12'(-int'($urandom_range(0, 2000)));
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	function automatic req_item_t make_item(input logic [1:0] kind, input logic [7:0] data,
			input logic last, input logic signed [11:0] rssi);
		req_item_t r;
		r.req_type = kind;
		r.rx_byte = data;
		r.rx_last = last;
		r.rssi_tenths = rssi;
		r.boost_dur = 8'($urandom_range(0, 255));
		return r;
	endfunction

	task automatic queue_request(input logic [1:0] kind, input logic [7:0] minutes);
		req_item_t r;
		r = make_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), any_rssi());
		r.boost_dur = minutes;
		pending_reqs.push_back(r);
	endtask

	task automatic put_byte(input int idx, input logic [7:0] val);
		if (idx < pkt.size())
			pkt[idx] = val;
	endtask

	task automatic make_packet(input int len, input logic [15:0] addr, input logic [7:0] ptype);
		pkt.delete();
		repeat (len)
			pkt.push_back(8'($urandom_range(0, 255)));
		put_byte(0, addr[15:8]);
		put_byte(1, addr[7:0]);
		put_byte(2, ptype);
	endtask

	task automatic set_heater(input logic [7:0] b5, b6, b7, b13, mode,
			input logic [31:0] energy);
		put_byte(5, b5);
		put_byte(6, b6);
		put_byte(7, b7);
		put_byte(13, b13);
		put_byte(24, mode);
		for (int i = 0; i < 4; i++)
			put_byte(25 + i, energy[8 * i +: 8]);
	endtask

	task automatic send_packet(input logic signed [11:0] rssi, input int cut);
		for (int i = 0; i < pkt.size(); i++) begin
			if (i == cut)
				queue_request(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
			pending_reqs.push_back(make_item(REQ_BYTE, pkt[i], i == pkt.size() - 1,
				(i == pkt.size() - 1) ? rssi : any_rssi()));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
		end else begin
			if (req_valid && req_ready) begin
				predict_request(req_data);
				accepted_total++;
			end
			send_cycles++;
			if (send_cycles % 50 == 0)
				send_pct = pick_pct();
			if (!req_valid || req_ready) begin
				if (send_gap == 0 && pending_reqs.size() > TAIL_ITEMS
						&& $urandom_range(0, 99) < send_pct)
					send_gap = $urandom_range(1, 14);
				if (send_gap > 0 || pending_reqs.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					req_valid <= 1'b0;
				end else begin
					req_valid <= 1'b1;
					req_data <= pending_reqs.pop_front();
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready)
				check_result(res_data);
			take_cycles++;
			if (take_cycles % 64 == 0)
				take_pct = pick_pct();
			if (stall_left == 0 && pending_reqs.size() > TAIL_ITEMS
					&& $urandom_range(0, 99) < take_pct)
				stall_left = $urandom_range(1, 14);
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int pick;
		int len;
		int cut;
		int rssi_v;
		logic [15:0] addr;
		logic [15:0] hint_addr;
		logic signed [11:0] hint_best;
		logic [7:0] ptype;

		// Requests before any address is known produce nothing.
		queue_request(REQ_POLL, 8'($urandom_range(0, 255)));
		queue_request(REQ_BOOST, 8'd45);
		make_packet(5, ADDR_A, TYPE_HEATER);
		send_packet(-12'sd2000, -1);
		make_packet(66, ADDR_A, TYPE_HEATER);
		send_packet(-12'sd1, -1);
		make_packet(10, ADDR_A, 8'h55);
		send_packet(12'sd0, -1);
		make_packet(27, ADDR_A, TYPE_BUDDY);
		send_packet(any_rssi(), -1);
		make_packet(20, ADDR_A, TYPE_SENDER);
		send_packet(any_rssi(), -1);
		make_packet(28, ADDR_A, TYPE_HEATER);
		set_heater(8'h00, 8'h00, 8'h00, 8'h00, MODE_FIRST, 32'h7F12_3456);
		send_packet(-12'sd1800, -1);
		make_packet(28, ADDR_B, TYPE_HEATER);
		send_packet(any_rssi(), -1);
		make_packet(28, ADDR_B, TYPE_BUDDY);
		send_packet(-12'sd1500, -1);
		make_packet(28, ADDR_A, TYPE_BUDDY);
		send_packet(-12'sd1500, -1);
		make_packet(44, ADDR_A, TYPE_SENDER);
		put_byte(12, BATT_LOW_MARK);
		send_packet(-12'sd1000, -1);
		make_packet(29, ADDR_A, TYPE_HEATER);
		set_heater(8'd30, 8'd1, 8'd9, 8'd1, MODE_FIRST + 8'd2, 32'h8000_0000);
		put_byte(16, 8'h00);
		put_byte(17, 8'h80);
		for (int i = 18; i < 22; i++)
			put_byte(i, (i == 21) ? 8'h80 : 8'h00);
		send_packet(any_rssi(), -1);
		queue_request(REQ_POLL, 8'($urandom_range(0, 255)));
		queue_request(REQ_BOOST, 8'd255);
		queue_request(REQ_CANCEL, 8'($urandom_range(0, 255)));
		queue_request(REQ_POLL, 8'($urandom_range(0, 255)));
		queue_request(REQ_BOOST, 8'd0);
		make_packet(28, ADDR_A, TYPE_HEATER);
		set_heater(8'h00, 8'h01, 8'h00, 8'h00, MODE_LAST, 32'h1);
		send_packet(any_rssi(), 12);

		hint_addr = ADDR_A;
		hint_best = -12'sd1000;
		while (pending_reqs.size() < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = ($urandom_range(0, 9) < 3) ? 28 :
					($urandom_range(0, 6) == 0) ? 29 : $urandom_range(28, 62);
				addr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : hint_addr;
				make_packet(len, addr, TYPE_HEATER);
				set_heater($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)),
					$urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)),
					($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom_range(1, 255)),
					($urandom_range(0, 2) != 0) ? 8'h00 : 8'($urandom_range(1, 255)),
					($urandom_range(0, 4) != 0) ? MODE_FIRST + 8'($urandom_range(0, 4)) :
						8'($urandom_range(0, 255)),
					($urandom_range(0, 3) == 0) ? 32'h0 :
						($urandom_range(0, 2) == 0) ? {1'b1, 31'($urandom)} : 32'($urandom));
				cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, len - 1) : -1;
				send_packet(any_rssi(), cut);
			end else if (pick < 67) begin
				ptype = (pick < 57) ? TYPE_BUDDY : TYPE_SENDER;
				len = $urandom_range((ptype == TYPE_BUDDY) ? 28 : 44, 62);
				addr = $urandom_range(0, 1) ? ADDR_A : ADDR_B;
				rssi_v = int'(hint_best) - 60 + int'($urandom_range(0, 80));
				if (rssi_v > 0)
					rssi_v = 0;
				make_packet(len, addr, ptype);
				if (ptype == TYPE_SENDER && $urandom_range(0, 1))
					put_byte(12, BATT_LOW_MARK);
				if (rssi_v > int'(hint_best)) begin
					hint_addr = addr;
					hint_best = 12'(rssi_v);
				end
				send_packet(12'(rssi_v), -1);
			end else if (pick < 85) begin
				queue_request(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 3))
					0: make_packet($urandom_range(1, 9), hint_addr, TYPE_HEATER);
					1: make_packet($urandom_range(63, 75), hint_addr, TYPE_BUDDY);
					2: begin
						ptype = 8'($urandom_range(0, 255));
						if (ptype == TYPE_HEATER || ptype == TYPE_BUDDY || ptype == TYPE_SENDER)
							ptype = ptype ^ 8'h80;
						make_packet($urandom_range(10, 62), hint_addr, ptype);
					end
					default: begin
						ptype = ($urandom_range(0, 2) == 0) ? TYPE_SENDER :
							($urandom_range(0, 1) ? TYPE_BUDDY : TYPE_HEATER);
						make_packet($urandom_range(10, (ptype == TYPE_SENDER) ? 43 : 27),
							hint_addr, ptype);
					end
				endcase
				send_packet(any_rssi(), -1);
			end
		end
		queued_total = pending_reqs.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (accepted_total != queued_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests; checked %0d results: %0d control frames, %0d heater reports,",
			accepted_total, results_seen, n_frames, n_reports);
		$display("%0d buddy or sender packets taken, %0d packets dropped, %0d mismatches.",
			n_accepts, n_drops, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
src/hrlh_pkg.sv
src/hrlh_pkt_decode.sv
src/heater_radio_link_handler_top.sv
bench/tb.sv
